// ===== sv/fat12_table_checker_top_macros.svh =====
// Assertion macros for the FAT12 table checker.
`ifndef FAT12_TABLE_CHECKER_TOP_MACROS_SVH
`define FAT12_TABLE_CHECKER_TOP_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define FTC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define FTC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define FTC_ASSERT_IMP(lbl, ante, cons, msg)
`define FTC_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== sv/fat12tc_pkg.sv =====
// Package with constants and the entry rule check of the FAT12 table checker.
package fat12tc_pkg;

	localparam int unsigned MAX_TABLE_SECTORS = 12;
	localparam int unsigned SECTOR_BYTES      = 512;
	localparam int unsigned TABLE_BYTES       = MAX_TABLE_SECTORS * SECTOR_BYTES;

	localparam logic [12:0] TABLE_BYTES_C = 13'(TABLE_BYTES);

	localparam logic [11:0] ENTRY0_BASE   = 12'hF00;
	localparam logic [11:0] CHAIN_END_MIN = 12'hFF8;
	localparam logic [11:0] BAD_CLUSTER   = 12'hFF7;

	localparam logic [7:0]  MEDIA_RESET   = 8'hF0;
	localparam logic [11:0] CLUSTER_RESET = 12'd2652;

	// Configuration register indexes.
	localparam logic REG_MEDIA_BYTE    = 1'b0;
	localparam logic REG_CLUSTER_COUNT = 1'b1;

	// Phase of a byte within its three-byte group.
	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_MIDDLE = 2'd1;
	localparam logic [1:0] PH_LAST   = 2'd2;

	typedef struct packed {
		logic length_error;
		logic secondary_invalid;
		logic primary_invalid;
		logic mirror_mismatch;
	} flags_t;

	// True if a 12-bit entry at the given index obeys the table rules.
	function automatic logic entry_ok(input logic [11:0] index, input logic [11:0] value,
			input logic [7:0] media, input logic [11:0] clusters);
		logic [12:0] last_idx;
		logic        ok;
		last_idx = {1'b0, clusters} + 13'd1;
		if (index == 12'd0) begin
			ok = (value == (ENTRY0_BASE | {4'd0, media}));
		end else if (index == 12'd1) begin
			ok = (value >= CHAIN_END_MIN);
		end else if ({1'b0, index} > last_idx) begin
			ok = 1'b1;
		end else begin
			ok = (value == 12'd0) ||
				((value >= 12'd2) && ({1'b0, value} <= last_idx)) ||
				(value == BAD_CLUSTER) || (value >= CHAIN_END_MIN);
		end
		return ok;
	endfunction

endpackage

// ===== sv/fat12_table_checker_top.sv =====
// Top level of the FAT12 table checker: unpacks and checks both table copies.
//
// Channel   Direction  Handshake                   Payload
// s_axis    in         s_axis_tvalid/tready        tdata: primary, mirror; tlast: last pair
// m_axis    out        m_axis_tvalid/tready        tdata: four result flags
// cfg       in         cfg_valid/cfg_ready         cfg_index, cfg_data
//
// One byte pair is taken per cycle while no last pair waits on a pending result;
// each pair passes through the input register, where its unpacking and entry checks
// run. The result of a table is loaded into the output register at the edge
// where its last pair leaves the input register.
// Reset loads the register defaults and clears the table state.
// A waiting result stalls only a following last pair; other pairs pass.
`include "fat12_table_checker_top_macros.svh"

module fat12_table_checker_top
	import fat12tc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [7:0] primary_byte, [15:8] mirror_byte
	input  logic        s_axis_tlast,   // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [0] mirror_mismatch, [1] primary_invalid,
	                                    // [2] secondary_invalid, [3] length_error, [7:4] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [11:0] cfg_data
);

	// Configuration registers.
	logic [7:0]  media_q;
	logic [11:0] clusters_q;

	// Input stage.
	logic        valid_s1;
	logic [7:0]  pbyte_s1;
	logic [7:0]  mbyte_s1;
	logic        last_s1;

	// Table state.
	logic [12:0] pos_q;
	logic [1:0]  phase_q;
	logic [11:0] grp_q;
	logic [7:0]  held_p_q;
	logic [7:0]  held_m_q;
	logic        mismatch_q;
	logic        pbad_q;
	logic        mbad_q;
	logic        overrun_q;

	// Output register.
	logic        out_valid_q;
	flags_t      flags_q;

	// Next-state signals.
	logic        fire_s1;
	logic        overrun;
	logic [11:0] idx;
	logic [11:0] pval;
	logic [11:0] mval;
	logic        check;
	logic [12:0] pos_n;
	logic [1:0]  phase_n;
	logic [11:0] grp_n;
	logic        mismatch_n;
	logic        pbad_n;
	logic        mbad_n;
	logic        overrun_n;
	logic [12:0] entries_n;
	logic        short_n;
	flags_t      flags_n;

	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, flags_q};

	// A last pair waits only while a previous result is still pending.
	assign fire_s1       = valid_s1 && !(last_s1 && out_valid_q && !m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire_s1;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			media_q    <= MEDIA_RESET;
			clusters_q <= CLUSTER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MEDIA_BYTE:    media_q    <= cfg_data[7:0];
				REG_CLUSTER_COUNT: clusters_q <= cfg_data;
				default:           media_q    <= media_q;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			pbyte_s1 <= s_axis_tdata[7:0];
			mbyte_s1 <= s_axis_tdata[15:8];
			last_s1  <= s_axis_tlast;
		end
	end

	// Unpacking and entry checks for the pair in the input register.
	always_comb begin
		overrun = (pos_q >= TABLE_BYTES_C);
		idx     = {grp_q[10:0], phase_q == PH_LAST};
		if (phase_q == PH_MIDDLE) begin
			pval = {pbyte_s1[3:0], held_p_q};
			mval = {mbyte_s1[3:0], held_m_q};
		end else begin
			pval = {pbyte_s1, held_p_q[7:4]};
			mval = {mbyte_s1, held_m_q[7:4]};
		end
		check      = !overrun && (phase_q != PH_FIRST);
		pos_n      = pos_q;
		phase_n    = phase_q;
		grp_n      = grp_q;
		mismatch_n = mismatch_q;
		pbad_n     = pbad_q;
		mbad_n     = mbad_q;
		overrun_n  = overrun_q;
		if (overrun) begin
			overrun_n = 1'b1;
		end else begin
			mismatch_n = mismatch_q || (pbyte_s1 != mbyte_s1);
			pos_n      = pos_q + 13'd1;
			if (phase_q == PH_LAST) begin
				phase_n = PH_FIRST;
				grp_n   = grp_q + 12'd1;
			end else begin
				phase_n = phase_q + 2'd1;
			end
		end
		if (check && !entry_ok(idx, pval, media_q, clusters_q)) begin
			pbad_n = 1'b1;
		end
		if (check && !entry_ok(idx, mval, media_q, clusters_q)) begin
			mbad_n = 1'b1;
		end
		// Completed entries: two per group plus one when two bytes of a group are in.
		entries_n = {grp_n, phase_n == PH_LAST};
		short_n   = (entries_n < ({1'b0, clusters_q} + 13'd2));
		flags_n.mirror_mismatch   = mismatch_n;
		flags_n.primary_invalid   = pbad_n || short_n;
		flags_n.secondary_invalid = mbad_n || short_n;
		flags_n.length_error      = overrun_n;
	end

	// Table state update; cleared after the last pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			phase_q    <= PH_FIRST;
			grp_q      <= '0;
			held_p_q   <= '0;
			held_m_q   <= '0;
			mismatch_q <= 1'b0;
			pbad_q     <= 1'b0;
			mbad_q     <= 1'b0;
			overrun_q  <= 1'b0;
		end else if (fire_s1) begin
			if (last_s1) begin
				pos_q      <= '0;
				phase_q    <= PH_FIRST;
				grp_q      <= '0;
				held_p_q   <= '0;
				held_m_q   <= '0;
				mismatch_q <= 1'b0;
				pbad_q     <= 1'b0;
				mbad_q     <= 1'b0;
				overrun_q  <= 1'b0;
			end else begin
				pos_q      <= pos_n;
				phase_q    <= phase_n;
				grp_q      <= grp_n;
				mismatch_q <= mismatch_n;
				pbad_q     <= pbad_n;
				mbad_q     <= mbad_n;
				overrun_q  <= overrun_n;
				if (!overrun) begin
					held_p_q <= (phase_q == PH_LAST) ? 8'd0 : pbyte_s1;
					held_m_q <= (phase_q == PH_LAST) ? 8'd0 : mbyte_s1;
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			flags_q <= flags_n;
		end
	end

	// Checks on the table state and the result path.
	`FTC_ASSERT_IMP(a_pos_bound, 1'b1, pos_q <= TABLE_BYTES_C, "byte position past table maximum")
	`FTC_ASSERT_IMP(a_phase_legal, 1'b1, phase_q != 2'd3, "group phase out of range")
	`FTC_ASSERT_NXT(a_result_after_last, fire_s1 && last_s1, m_axis_tvalid,
		"no result after last pair")
	`FTC_ASSERT_NXT(a_clear_after_last, fire_s1 && last_s1, pos_q == 13'd0 && !overrun_q,
		"table state not cleared after last pair")

endmodule

// ===== tb/tb_fat12_table_checker_top.sv =====
// Self-checking testbench for the FAT12 table checker top level.
module tb_fat12_table_checker_top;
	import fat12tc_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_REPORTS  = 10;

	typedef logic [7:0]  byte_q_t[$];
	typedef logic [11:0] entry_q_t[$];

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;   // [7:0] primary_byte, [15:8] mirror_byte
	logic        s_axis_tlast;   // last_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;   // [0] mirror_mismatch, [1] primary_invalid,
	                             // [2] secondary_invalid, [3] length_error
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [11:0] cfg_data;

	// Shadow configuration and per-table state of the checker.
	logic [7:0]  media_reg;
	logic [11:0] clusters_reg;
	logic [12:0] pos_count;
	logic [15:0] held_prim;
	logic [15:0] held_mirr;
	bit          seen_mismatch;
	bit          prim_broken;
	bit          mirr_broken;
	bit          seen_overrun;

	flags_t pending_flags[$];
	int     error_count;
	int     cycle_count;
	int     send_idle_pct;
	int     recv_idle_pct;

	fat12_table_checker_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Abort the run if it hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// True if a 12-bit entry at the given index obeys the allocation rules.
	function automatic bit entry_legal(int unsigned idx, logic [11:0] val);
		int unsigned top;
		top = int'(clusters_reg) + 1;
		if (idx == 0)
			return val == (ENTRY0_BASE | {4'h0, media_reg});
		if (idx == 1)
			return val >= CHAIN_END_MIN;
		if (idx > top)
			return 1'b1;
		return (val == 12'd0) || (val >= 12'd2 && val <= top) ||
			(val == BAD_CLUSTER) || (val >= CHAIN_END_MIN);
	endfunction

	// Feeds one byte of a copy into its three-byte group; false on a broken entry.
	function automatic bit unpack_byte(inout logic [15:0] held, input logic [7:0] b,
			input logic [12:0] pos);
		int unsigned idx;
		logic [11:0] val;
		idx = (2 * int'(pos)) / 3;
		case (2'(pos % 3))
			PH_FIRST: begin
				held = {8'h00, b};
				return 1'b1;
			end
			PH_MIDDLE: begin
				val = {b[3:0], held[7:0]};
				held = {8'h00, b};
				return entry_legal(idx, val);
			end
			default: begin
				val = {b, held[7:4]};
				held = 16'h0000;
				return entry_legal(idx, val);
			end
		endcase
	endfunction

	task automatic clear_table_state();
		pos_count     = '0;
		held_prim     = '0;
		held_mirr     = '0;
		seen_mismatch = 1'b0;
		prim_broken   = 1'b0;
		mirr_broken   = 1'b0;
		seen_overrun  = 1'b0;
	endtask

	// Updates the shadow state for one accepted byte pair and queues the flags
	// of a finished table.
	task automatic absorb_pair(logic [7:0] p, logic [7:0] m, logic is_last);
		flags_t f;
		if (pos_count >= TABLE_BYTES_C) begin
			seen_overrun = 1'b1;
		end else begin
			if (p != m)
				seen_mismatch = 1'b1;
			if (!unpack_byte(held_prim, p, pos_count))
				prim_broken = 1'b1;
			if (!unpack_byte(held_mirr, m, pos_count))
				mirr_broken = 1'b1;
			pos_count = pos_count + 13'd1;
		end
		if (is_last) begin
			// A table that stops before its last checked entry fails in both copies.
			if ((2 * int'(pos_count)) / 3 < int'(clusters_reg) + 2) begin
				prim_broken = 1'b1;
				mirr_broken = 1'b1;
			end
			f.mirror_mismatch   = seen_mismatch;
			f.primary_invalid   = prim_broken;
			f.secondary_invalid = mirr_broken;
			f.length_error      = seen_overrun;
			pending_flags.push_back(f);
			clear_table_state();
		end
	endtask

	// Compares each result transfer with the oldest pending flag set.
	always @(posedge clk) begin
		flags_t want;
		flags_t got;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = flags_t'(m_axis_tdata[3:0]);
				if (pending_flags.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("unexpected result: tdata=%h", m_axis_tdata);
				end else begin
					want = pending_flags.pop_front();
					if (got.mirror_mismatch !== want.mirror_mismatch ||
							got.primary_invalid !== want.primary_invalid ||
							got.secondary_invalid !== want.secondary_invalid ||
							got.length_error !== want.length_error ||
							m_axis_tdata[7:4] !== 4'h0) begin
						error_count++;
						if (error_count <= MAX_REPORTS)
							$display("flag mismatch: mm/pi/si/le expected %b%b%b%b, got %b%b%b%b (tdata=%h)",
								want.mirror_mismatch, want.primary_invalid,
								want.secondary_invalid, want.length_error,
								got.mirror_mismatch, got.primary_invalid,
								got.secondary_invalid, got.length_error, m_axis_tdata);
					end
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Sends one byte pair, with random idle cycles ahead of it.
	task automatic send_pair(logic [7:0] p, logic [7:0] m, logic is_last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {m, p};
		s_axis_tlast  <= is_last;
		do @(posedge clk); while (!s_axis_tready);
		absorb_pair(p, m, is_last);
	endtask

	task automatic send_table(byte_q_t p, byte_q_t m);
		for (int i = 0; i < p.size(); i++)
			send_pair(p[i], m[i], i == p.size() - 1);
	endtask

	// Waits until every pending result has arrived and the pipeline is empty.
	task automatic wait_quiet();
		s_axis_tvalid <= 1'b0;
		while (pending_flags.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes both registers back to back; the media write carries junk above bit 7.
	task automatic set_config(logic [7:0] media, logic [11:0] clusters);
		cfg_valid <= 1'b1;
		cfg_index <= REG_MEDIA_BYTE;
		cfg_data  <= {4'($urandom_range(15)), media};
		do @(posedge clk); while (!cfg_ready);
		media_reg = media;
		cfg_index <= REG_CLUSTER_COUNT;
		cfg_data  <= clusters;
		do @(posedge clk); while (!cfg_ready);
		clusters_reg = clusters;
		cfg_valid <= 1'b0;
	endtask

	// Packs 12-bit entries into bytes, two entries per three bytes.
	function automatic byte_q_t pack_entries(entry_q_t ents, int nbytes);
		byte_q_t q;
		int k;
		for (int pos = 0; pos < nbytes; pos++) begin
			k = (pos / 3) * 2;
			case (pos % 3)
				0: q.push_back(ents[k][7:0]);
				1: q.push_back({ents[k + 1][3:0], ents[k][11:8]});
				default: q.push_back(ents[k + 1][11:4]);
			endcase
		end
		return q;
	endfunction

	// Random entry that passes the rule for its index under the current setting.
	function automatic logic [11:0] legal_entry(int idx);
		int top;
		int hi;
		top = int'(clusters_reg) + 1;
		hi  = (top > 'hFFF) ? 'hFFF : top;
		if (idx == 0)
			return ENTRY0_BASE | {4'h0, media_reg};
		if (idx == 1)
			return 12'($urandom_range('hFFF, 'hFF8));
		if (idx > top)
			return 12'($urandom);
		case ($urandom_range(3))
			0: return 12'd0;
			1: return (hi >= 2) ? 12'($urandom_range(hi, 2)) : 12'd0;
			2: return BAD_CLUSTER;
			default: return 12'($urandom_range('hFFF, 'hFF8));
		endcase
	endfunction

	// Random entry that breaks the rule for its index; index must be checked.
	function automatic logic [11:0] illegal_entry(int idx);
		int top;
		top = int'(clusters_reg) + 1;
		if (idx == 0)
			return (ENTRY0_BASE | {4'h0, media_reg}) ^ (12'h001 << $urandom_range(11, 0));
		if (idx == 1)
			return 12'($urandom_range('hFF7, 0));
		if (top + 1 <= 'hFF6 && $urandom_range(1))
			return 12'($urandom_range('hFF6, top + 1));
		return 12'd1;
	endfunction

	function automatic entry_q_t legal_entries(int nbytes);
		entry_q_t e;
		for (int i = 0; i < 2 * ((nbytes + 2) / 3); i++)
			e.push_back(legal_entry(i));
		return e;
	endfunction

	// Builds one random table pair: mostly well formed, some short, long or noise.
	task automatic make_random_table(output byte_q_t p, output byte_q_t m);
		int full;
		int nbytes;
		int kind;
		int lim;
		int idx;
		entry_q_t pe;
		entry_q_t me;
		p.delete();
		m.delete();
		full = (3 * (int'(clusters_reg) + 2) + 1) / 2;
		kind = $urandom_range(99);
		if (kind < 12) begin
			nbytes = $urandom_range(full + 4, 1);
			for (int i = 0; i < nbytes; i++)
				p.push_back(8'($urandom));
			if ($urandom_range(1)) begin
				m = p;
			end else begin
				for (int i = 0; i < nbytes; i++)
					m.push_back(8'($urandom));
			end
		end else begin
			if (kind < 24 && full > 1)
				nbytes = $urandom_range(full - 1, 1);
			else if (kind < 34)
				nbytes = full + $urandom_range(6, 1);
			else
				nbytes = full;
			pe  = legal_entries(nbytes);
			lim = int'(clusters_reg) + 1;
			if (lim > pe.size() - 1)
				lim = pe.size() - 1;
			if ($urandom_range(99) < 20) begin
				idx = $urandom_range(lim, 0);
				pe[idx] = illegal_entry(idx);
			end
			me = pe;
			if ($urandom_range(99) < 20) begin
				idx = $urandom_range(lim, 0);
				me[idx] = illegal_entry(idx);
			end
			p = pack_entries(pe, nbytes);
			m = pack_entries(me, nbytes);
			if ($urandom_range(99) < 15) begin
				idx = $urandom_range(nbytes - 1, 0);
				m[idx] = m[idx] ^ (8'h01 << $urandom_range(7, 0));
			end
		end
	endtask

	// A full legal table under the register defaults.
	task automatic test_reset_defaults();
		byte_q_t p;
		int nbytes;
		nbytes = (3 * (int'(clusters_reg) + 2) + 1) / 2;
		p = pack_entries(legal_entries(nbytes), nbytes);
		send_table(p, p);
	endtask

	// Each entry rule on both copies, plus a short table and a one-pair table.
	task automatic test_entry_rules();
		byte_q_t p;
		byte_q_t m;
		wait_quiet();
		set_config(8'hFF, 12'd2);
		p = pack_entries('{12'hFFF, 12'hFF8, 12'h002, 12'h003}, 6);
		send_table(p, p);
		p = pack_entries('{12'hF00, 12'hFF7, 12'h000, 12'h000}, 6);
		m = pack_entries('{12'hFFF, 12'hFFF, 12'h001, 12'h004}, 6);
		send_table(p, m);
		p = pack_entries('{12'hFFF, 12'hFFF, 12'hFF7, 12'h000}, 6);
		m = pack_entries('{12'hFFF, 12'hFFF, 12'hFF7, 12'hFF6}, 6);
		send_table(p, m);
		p = pack_entries('{12'hFFF, 12'hFFF, 12'h000, 12'h000}, 5);
		send_table(p, p);
		p = '{8'hFF};
		send_table(p, p);
	endtask

	// A legal table at a cluster count of 4084 followed by pairs past the maximum.
	task automatic test_overrun();
		byte_q_t p;
		byte_q_t m;
		int nbytes;
		wait_quiet();
		set_config(8'h00, 12'd4084);
		nbytes = TABLE_BYTES + 3;
		p = pack_entries(legal_entries(nbytes), nbytes);
		m = p;
		// Differences past the maximum are not compared.
		m[nbytes - 2] = ~p[nbytes - 2];
		send_table(p, m);
	endtask

	// Cluster counts of zero, one and the 12-bit maximum.
	task automatic test_cluster_extremes();
		byte_q_t p;
		entry_q_t e;
		wait_quiet();
		set_config(8'($urandom), 12'd0);
		p = pack_entries(legal_entries(3), 3);
		send_table(p, p);
		e = legal_entries(6);
		e[2] = 12'h001;
		e[3] = 12'hFF6;
		p = pack_entries(e, 6);
		send_table(p, p);
		wait_quiet();
		set_config(8'($urandom), 12'd1);
		p = pack_entries(legal_entries(5), 5);
		send_table(p, p);
		// Above the valid range no table can be long enough; codes near the
		// bad marker fall inside the cluster range.
		wait_quiet();
		set_config(8'($urandom), 12'hFFF);
		e = legal_entries(TABLE_BYTES);
		e[5] = 12'hFF6;
		p = pack_entries(e, TABLE_BYTES);
		send_table(p, p);
	endtask

	// Random tables under several random settings at the given idle rates.
	task automatic test_random(int s_idle, int r_idle, int budget);
		byte_q_t p;
		byte_q_t m;
		int sent;
		logic [7:0] media;
		logic [11:0] clusters;
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		for (int g = 0; g < 3; g++) begin
			wait_quiet();
			case ($urandom_range(9))
				0: media = 8'h00;
				1: media = 8'hFF;
				default: media = 8'($urandom);
			endcase
			case ($urandom_range(19))
				0: clusters = 12'd0;
				1: clusters = 12'd1;
				2: clusters = 12'($urandom_range(200, 41));
				default: clusters = 12'($urandom_range(40, 2));
			endcase
			set_config(media, clusters);
			sent = 0;
			while (sent < budget / 3) begin
				make_random_table(p, m);
				send_table(p, m);
				sent += p.size();
			end
		end
	endtask

	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tlast  <= 1'b0;
		m_axis_tready <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_index     <= REG_MEDIA_BYTE;
		cfg_data      <= '0;
		error_count   = 0;
		cycle_count   = 0;
		send_idle_pct = 28;
		recv_idle_pct = 83;
		media_reg     = MEDIA_RESET;
		clusters_reg  = CLUSTER_RESET;
		clear_table_state();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_entry_rules();
		test_overrun();
		test_cluster_extremes();
		test_random(28, 83, 650);
		test_random(83, 28, 650);
		test_random(0, 0, 650);

		wait_quiet();
		if (error_count == 0 && pending_flags.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
